// File: rtl/paged_byte_memory_core_assert.svh
// assertion macros shared by the paged byte memory rtl
`ifndef PAGED_BYTE_MEMORY_CORE_ASSERT_SVH
`define PAGED_BYTE_MEMORY_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication, checked out of reset
`define PBM_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("paged byte memory check failed");
// next-cycle implication, checked out of reset
`define PBM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("paged byte memory check failed");
`else
`define PBM_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define PBM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// File: rtl/pbm_pkg.sv
// types and constants of the paged byte memory
package pbm_pkg;

  localparam int unsigned LANES = 8;
  localparam logic [3:0] MAX_BYTES = 4'd8;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_UNALLOC  = 2'd1,
    ST_ZERO     = 2'd2,
    ST_PAST_TOP = 2'd3
  } status_t;

  typedef struct packed {
    logic        operation;
    logic [15:0] address;
    logic [3:0]  byte_count;
    logic [63:0] write_data;
  } in_beat_t;

  typedef struct packed {
    logic [63:0] read_data;
    status_t     status;
  } out_beat_t;

  // command broadcast to every byte lane
  typedef struct packed {
    logic        wr;
    logic [2:0]  lo;
    logic [3:0]  count;
    logic [63:0] wdata;
  } lane_cmd_t;

  // what the merge stage needs about the beat in flight
  typedef struct packed {
    logic       read_ok;
    logic [2:0] lo;
    logic [3:0] count;
    status_t    status;
  } merge_ctl_t;

endpackage

// File: rtl/pbm_lane.sv
// one byte-lane bank: holds every address whose low three bits equal the lane number
module pbm_lane #(
  parameter int ROW_BITS = 13,
  parameter int LANE     = 0
) (
  input  logic                  clk,
  input  pbm_pkg::lane_cmd_t    cmd,
  input  logic [ROW_BITS-1:0]   row_base,
  output logic [7:0]            rbyte
);
  import pbm_pkg::*;

  localparam int Depth = 1 << ROW_BITS;

  logic [7:0]          mem_r [Depth];
  logic [7:0]          rdata_r;
  logic [2:0]          k;
  logic                active;
  logic                wraps;
  logic [ROW_BITS-1:0] row;
  logic [7:0]          wbyte;

  // position of this lane inside the beat and the row it touches
  always_comb begin
    k      = 3'(LANE) - cmd.lo;
    active = {1'b0, k} < cmd.count;
    wraps  = 3'(LANE) < cmd.lo;
    row    = row_base + ROW_BITS'(wraps);
    wbyte  = cmd.wdata[8*k +: 8];
  end

  // bank write
  always_ff @(posedge clk) begin
    if (cmd.wr && active) begin
      mem_r[row] <= wbyte;
    end
  end

  // registered bank read
  always_ff @(posedge clk) begin
    rdata_r <= mem_r[row];
  end

  assign rbyte = rdata_r;

endmodule

// File: rtl/pbm_merge.sv
// merge stage: rotates lane bytes back into beat order and masks unused bytes
module pbm_merge (
  input  logic [7:0][7:0]      lane_bytes,
  input  pbm_pkg::merge_ctl_t  ctl,
  output pbm_pkg::out_beat_t   out_beat
);
  import pbm_pkg::*;

  always_comb begin
    logic [2:0] sel;
    sel = '0;
    out_beat.read_data = '0;
    out_beat.status    = ctl.status;
    // byte k of the beat lives in lane lo + k
    for (int k = 0; k < LANES; k++) begin
      sel = ctl.lo + 3'(k);
      if (ctl.read_ok && (4'(k) < ctl.count)) begin
        out_beat.read_data[8*k +: 8] = lane_bytes[sel];
      end
    end
  end

endmodule

// File: rtl/paged_byte_memory_core.sv
// paged byte memory: eight byte-lane banks, page map and merge stage
// one beat accepted per cycle while busy is low; its result strobes in the cycle after acceptance
// latency is set by the registered reads of the byte-lane banks and the page map
// after reset the banks and page map are zeroed one row a cycle, all 2^(ADDR_WIDTH-3)
// rows (8192 at the defaults), with busy high
// results cannot be stalled: out_valid is a single-cycle strobe
`include "paged_byte_memory_core_assert.svh"

module paged_byte_memory_core #(
  parameter int ADDR_WIDTH        = 16,
  parameter int PAGE_OFFSET_WIDTH = 10
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  pbm_pkg::in_beat_t   in_data,
  output logic                out_valid,
  output pbm_pkg::out_beat_t  out_data
);
  import pbm_pkg::*;

  localparam int RowBits     = ADDR_WIDTH - 3;
  localparam int PageBits    = (ADDR_WIDTH > PAGE_OFFSET_WIDTH) ?
                               ADDR_WIDTH - PAGE_OFFSET_WIDTH : 0;
  localparam int PageIdxBits = (PageBits > 0) ? PageBits : 1;
  localparam int PageCount   = 1 << PageIdxBits;

  logic                   clearing_r, clearing_nxt;
  logic [RowBits-1:0]     clr_cnt_r, clr_cnt_nxt;
  logic                   out_valid_r;
  merge_ctl_t             ctl_r, ctl_nxt;
  logic                   page_r [PageCount];
  logic                   pg_first_ok_r, pg_last_ok_r;

  logic                   accept;
  logic [31:0]            addr32;
  logic [ADDR_WIDTH-1:0]  addr;
  logic [3:0]             cnt;
  logic [ADDR_WIDTH:0]    last_ext;
  logic [ADDR_WIDTH-1:0]  last;
  logic [ADDR_WIDTH-1:0]  addr_sh, last_sh;
  logic [PageIdxBits-1:0] pg_first, pg_last;
  logic [PageIdxBits-1:0] clr_page;
  logic                   do_write;
  lane_cmd_t              cmd;
  logic [RowBits-1:0]     row_base;
  logic [7:0][7:0]        lane_bytes;
  merge_ctl_t             ctl_out;

  assign busy   = clearing_r;
  assign accept = start && !clearing_r;

  // address decode and range checks; page check follows in the result cycle
  always_comb begin
    addr32   = {16'b0, in_data.address};
    addr     = addr32[ADDR_WIDTH-1:0];
    cnt      = (in_data.byte_count > MAX_BYTES) ? MAX_BYTES : in_data.byte_count;
    last_ext = {1'b0, addr} + (ADDR_WIDTH+1)'(cnt) - (ADDR_WIDTH+1)'(1);
    last     = last_ext[ADDR_WIDTH-1:0];
    addr_sh  = addr >> PAGE_OFFSET_WIDTH;
    last_sh  = last >> PAGE_OFFSET_WIDTH;
    pg_first = addr_sh[PageIdxBits-1:0];
    pg_last  = last_sh[PageIdxBits-1:0];

    do_write        = 1'b0;
    ctl_nxt.read_ok = 1'b0;
    ctl_nxt.lo      = addr[2:0];
    ctl_nxt.count   = cnt;
    ctl_nxt.status  = ST_OK;
    if (cnt != 4'd0) begin
      if (last_ext[ADDR_WIDTH]) begin
        ctl_nxt.status = ST_PAST_TOP;
      end else if (in_data.operation) begin
        if (addr == '0) begin
          ctl_nxt.status = ST_ZERO;
        end else begin
          do_write = 1'b1;
        end
      end else begin
        ctl_nxt.read_ok = 1'b1;
      end
    end
  end

  // lane command: clearing pass or the accepted beat
  always_comb begin
    if (clearing_r) begin
      cmd.wr    = 1'b1;
      cmd.lo    = 3'd0;
      cmd.count = MAX_BYTES;
      cmd.wdata = '0;
      row_base  = clr_cnt_r;
    end else begin
      cmd.wr    = accept && do_write;
      cmd.lo    = addr[2:0];
      cmd.count = cnt;
      cmd.wdata = in_data.write_data;
      row_base  = addr[ADDR_WIDTH-1:3];
    end
  end

  // clearing pass sequencing
  always_comb begin
    clr_cnt_nxt  = clr_cnt_r;
    clearing_nxt = clearing_r;
    if (clearing_r) begin
      clr_cnt_nxt = clr_cnt_r + RowBits'(1);
      if (clr_cnt_r == '1) begin
        clearing_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r  <= 1'b1;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      clearing_r  <= clearing_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= accept;
    end
  end

  // control of the beat in flight
  always_ff @(posedge clk) begin
    if (accept) begin
      ctl_r <= ctl_nxt;
    end
  end

  assign clr_page = clr_cnt_r[PageIdxBits-1:0];

  // page map: cleared by the clearing pass, a write allocates the pages
  // of its first and last byte
  always_ff @(posedge clk) begin
    if (clearing_r) begin
      page_r[clr_page] <= 1'b0;
    end else if (accept && do_write) begin
      page_r[pg_first] <= 1'b1;
      if (pg_last != pg_first) begin
        page_r[pg_last] <= 1'b1;
      end
    end
  end

  // registered page map read for the beat being accepted
  always_ff @(posedge clk) begin
    pg_first_ok_r <= page_r[pg_first];
    pg_last_ok_r  <= page_r[pg_last];
  end

  // a read touching an unallocated page is flagged and returns zero
  always_comb begin
    ctl_out = ctl_r;
    if (ctl_r.read_ok && !(pg_first_ok_r && pg_last_ok_r)) begin
      ctl_out.read_ok = 1'b0;
      ctl_out.status  = ST_UNALLOC;
    end
  end

  // byte-lane banks
  for (genvar g = 0; g < LANES; g++) begin : g_lane
    pbm_lane #(
      .ROW_BITS (RowBits),
      .LANE     (g)
    ) u_lane (
      .clk      (clk),
      .cmd      (cmd),
      .row_base (row_base),
      .rbyte    (lane_bytes[g])
    );
  end

  pbm_merge u_merge (
    .lane_bytes (lane_bytes),
    .ctl        (ctl_out),
    .out_beat   (out_data)
  );

  assign out_valid = out_valid_r;

  // checks
  `PBM_ASSERT_NEXT(a_accept_strobes, clk, rst_n, accept, out_valid_r)
  `PBM_ASSERT_IMPLY(a_no_result_in_clear, clk, rst_n, clearing_r, !out_valid_r)
  `PBM_ASSERT_IMPLY(a_error_reads_zero, clk, rst_n,
                    out_valid_r && (out_data.status != ST_OK), out_data.read_data == '0)
  `PBM_ASSERT_IMPLY(a_read_ok_status, clk, rst_n,
                    out_valid_r && ctl_r.read_ok, ctl_r.status == ST_OK)

endmodule
